### sv/imufpd_pkg.sv
// shared types, constants and register codes of the imu fifo packet decoder
package imufpd_pkg;

   localparam int PKT_LEN             = 20;
   localparam int POS_W               = 5;
   localparam int SCALE_FRAC_BITS_DEF = 14;

   localparam logic [7:0] HDR_REJECT_MASK  = 8'h80;
   localparam logic [7:0] HDR_REQUIRE_MASK = 8'h10;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 60;

   localparam logic [15:0] ACCEL_SCALE_RESET = 16'd16384;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACCEL_OFFSET_X = 3'd0,
      CSR_ACCEL_OFFSET_Y = 3'd1,
      CSR_ACCEL_OFFSET_Z = 3'd2,
      CSR_ACCEL_SCALE_X  = 3'd3,
      CSR_ACCEL_SCALE_Y  = 3'd4,
      CSR_ACCEL_SCALE_Z  = 3'd5,
      CSR_GYRO_OFFSETS   = 3'd6
   } csr_index_type;

   // one decoded packet on its way from the framer to the arithmetic
   typedef struct packed {
      logic               rejected;
      logic signed [17:0] accel_x;
      logic signed [17:0] accel_y;
      logic signed [17:0] accel_z;
      logic signed [18:0] gyro_x;
      logic signed [18:0] gyro_y;
      logic signed [18:0] gyro_z;
   } packet_type;

endpackage

### sv/imu_fifo_packet_decoder.sv
// One FIFO byte is taken per clock while req_ready is high; req_ready drops only when the
// two-entry packet queue is full, which needs the response side to hold off for about four
// packets. The twentieth byte of a packet leaves the framer as a decoded request and is
// written into the packet queue; from there its result passes the offset and multiply
// stage and then the round and clamp stage that feeds the output register, where it shows
// on rsp_valid. A result carries status 1 and zero axes when the header has bit 7 set or
// bit 4 clear. The csr port takes one register write per cycle and is to be written only
// while no packet is in flight.
module imu_fifo_packet_decoder #(
   parameter int SCALE_FRAC_BITS = imufpd_pkg::SCALE_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_packet_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [20:0]                 rsp_accel_x,
   output logic signed [20:0]                 rsp_accel_y,
   output logic signed [20:0]                 rsp_accel_z,
   output logic signed [19:0]                 rsp_gyro_x,
   output logic signed [19:0]                 rsp_gyro_y,
   output logic signed [19:0]                 rsp_gyro_z,
   output logic                               rsp_status,
   input  logic                               csr_write_enable,
   input  logic [imufpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [imufpd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import imufpd_pkg::*;

   logic signed [18:0] accel_offset_x_ff, accel_offset_x_in;
   logic signed [18:0] accel_offset_y_ff, accel_offset_y_in;
   logic signed [18:0] accel_offset_z_ff, accel_offset_z_in;
   logic [15:0]        accel_scale_x_ff, accel_scale_x_in;
   logic [15:0]        accel_scale_y_ff, accel_scale_y_in;
   logic [15:0]        accel_scale_z_ff, accel_scale_z_in;
   logic [59:0]        gyro_offsets_ff, gyro_offsets_in;

   logic       push_valid, push_ready;
   packet_type push_packet;
   logic       pop_valid, pop_ready;
   packet_type pop_packet;

   always_comb begin
      accel_offset_x_in = accel_offset_x_ff;
      accel_offset_y_in = accel_offset_y_ff;
      accel_offset_z_in = accel_offset_z_ff;
      accel_scale_x_in  = accel_scale_x_ff;
      accel_scale_y_in  = accel_scale_y_ff;
      accel_scale_z_in  = accel_scale_z_ff;
      gyro_offsets_in   = gyro_offsets_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACCEL_OFFSET_X: accel_offset_x_in = csr_write_data[18:0];
            CSR_ACCEL_OFFSET_Y: accel_offset_y_in = csr_write_data[18:0];
            CSR_ACCEL_OFFSET_Z: accel_offset_z_in = csr_write_data[18:0];
            CSR_ACCEL_SCALE_X:  accel_scale_x_in  = csr_write_data[15:0];
            CSR_ACCEL_SCALE_Y:  accel_scale_y_in  = csr_write_data[15:0];
            CSR_ACCEL_SCALE_Z:  accel_scale_z_in  = csr_write_data[15:0];
            CSR_GYRO_OFFSETS:   gyro_offsets_in   = csr_write_data[59:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_offset_x_ff <= '0;
         accel_offset_y_ff <= '0;
         accel_offset_z_ff <= '0;
         accel_scale_x_ff  <= ACCEL_SCALE_RESET;
         accel_scale_y_ff  <= ACCEL_SCALE_RESET;
         accel_scale_z_ff  <= ACCEL_SCALE_RESET;
         gyro_offsets_ff   <= '0;
      end else begin
         accel_offset_x_ff <= accel_offset_x_in;
         accel_offset_y_ff <= accel_offset_y_in;
         accel_offset_z_ff <= accel_offset_z_in;
         accel_scale_x_ff  <= accel_scale_x_in;
         accel_scale_y_ff  <= accel_scale_y_in;
         accel_scale_z_ff  <= accel_scale_z_in;
         gyro_offsets_ff   <= gyro_offsets_in;
      end
   end

   imufpd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_packet_start (req_packet_start),
      .push_valid       (push_valid),
      .push_packet      (push_packet),
      .push_ready       (push_ready)
   );

   imufpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  (push_packet),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_data  (pop_packet)
   );

   imufpd_back #(
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (pop_valid),
      .item_ready     (pop_ready),
      .item           (pop_packet),
      .accel_offset_x (accel_offset_x_ff),
      .accel_offset_y (accel_offset_y_ff),
      .accel_offset_z (accel_offset_z_ff),
      .accel_scale_x  (accel_scale_x_ff),
      .accel_scale_y  (accel_scale_y_ff),
      .accel_scale_z  (accel_scale_z_ff),
      .gyro_offsets   (gyro_offsets_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_accel_x    (rsp_accel_x),
      .rsp_accel_y    (rsp_accel_y),
      .rsp_accel_z    (rsp_accel_z),
      .rsp_gyro_x     (rsp_gyro_x),
      .rsp_gyro_y     (rsp_gyro_y),
      .rsp_gyro_z     (rsp_gyro_z),
      .rsp_status     (rsp_status)
   );

endmodule

### sv/imufpd_front.sv
// byte framer: collects one packet, checks the header and unpacks the raw axes
module imufpd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_packet_start,
   output logic                    push_valid,
   output imufpd_pkg::packet_type  push_packet,
   input  logic                    push_ready
);
   import imufpd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       store_ff [PKT_LEN-1];
   logic             accept;
   logic             last_byte;
   logic [7:0]       header;
   logic [19:0]      ax20, ay20, az20, gx20, gy20, gz20;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign last_byte = (pos_ff == POS_W'(PKT_LEN - 1));

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_packet_start) begin
            pos_in = POS_W'(1);
         end else if (pos_ff != '0) begin
            pos_in = last_byte ? '0 : pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // the final byte is used straight from the bus, never stored
   always_ff @(posedge clock) begin
      if (accept && req_packet_start) begin
         store_ff[0] <= req_data_byte;
      end else if (accept && pos_ff != '0 && !last_byte) begin
         store_ff[pos_ff] <= req_data_byte;
      end
   end

   assign push_valid = accept && !req_packet_start && last_byte;

   assign header = store_ff[0];
   assign ax20 = {store_ff[1],  store_ff[2],  store_ff[17][7:4]};
   assign ay20 = {store_ff[3],  store_ff[4],  store_ff[18][7:4]};
   assign az20 = {store_ff[5],  store_ff[6],  req_data_byte[7:4]};
   assign gx20 = {store_ff[7],  store_ff[8],  store_ff[17][3:0]};
   assign gy20 = {store_ff[9],  store_ff[10], store_ff[18][3:0]};
   assign gz20 = {store_ff[11], store_ff[12], req_data_byte[3:0]};

   always_comb begin
      push_packet.rejected = ((header & HDR_REJECT_MASK) != '0) ||
                             ((header & HDR_REQUIRE_MASK) == '0);
      // arithmetic shift right is a plain drop of the low bits
      push_packet.accel_x = ax20[19:2];
      push_packet.accel_y = ay20[19:2];
      push_packet.accel_z = az20[19:2];
      push_packet.gyro_x  = gx20[19:1];
      push_packet.gyro_y  = gy20[19:1];
      push_packet.gyro_z  = gz20[19:1];
   end

endmodule

### sv/imufpd_queue.sv
// two-entry packet queue between the framer and the arithmetic pipeline
module imufpd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_valid,
   output logic                    wr_ready,
   input  imufpd_pkg::packet_type  wr_data,
   output logic                    rd_valid,
   input  logic                    rd_ready,
   output imufpd_pkg::packet_type  rd_data
);
   import imufpd_pkg::*;

   packet_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   push, pop;

   assign wr_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entries_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### sv/imufpd_back.sv
// arithmetic pipeline: offset, scale, rounding and saturation of one packet
module imufpd_back #(
   parameter int SCALE_FRAC_BITS = imufpd_pkg::SCALE_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   output logic                    item_ready,
   input  imufpd_pkg::packet_type  item,
   input  logic signed [18:0]      accel_offset_x,
   input  logic signed [18:0]      accel_offset_y,
   input  logic signed [18:0]      accel_offset_z,
   input  logic [15:0]             accel_scale_x,
   input  logic [15:0]             accel_scale_y,
   input  logic [15:0]             accel_scale_z,
   input  logic [59:0]             gyro_offsets,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [20:0]      rsp_accel_x,
   output logic signed [20:0]      rsp_accel_y,
   output logic signed [20:0]      rsp_accel_z,
   output logic signed [19:0]      rsp_gyro_x,
   output logic signed [19:0]      rsp_gyro_y,
   output logic signed [19:0]      rsp_gyro_z,
   output logic                    rsp_status
);
   import imufpd_pkg::*;

   localparam logic signed [37:0] ROUND_ADD = 38'sd1 <<< (SCALE_FRAC_BITS - 1);

   function automatic logic signed [20:0] sat_accel(input logic signed [36:0] prod);
      logic signed [37:0] sum;
      logic signed [37:0] shifted;
      sum     = {prod[36], prod} + ROUND_ADD;
      shifted = sum >>> SCALE_FRAC_BITS;
      if (shifted > 38'sd1048575) begin
         return 21'sh0FFFFF;
      end else if (shifted < -38'sd1048576) begin
         return 21'sh100000;
      end
      return shifted[20:0];
   endfunction

   function automatic logic signed [19:0] sat_gyro(input logic signed [20:0] v);
      if (v > 21'sd524287) begin
         return 20'sh7FFFF;
      end else if (v < -21'sd524288) begin
         return 20'sh80000;
      end
      return v[19:0];
   endfunction

   logic                a_valid_ff, a_valid_in;
   logic                a_rejected_ff;
   logic signed [36:0]  a_prod_x_ff, a_prod_y_ff, a_prod_z_ff;
   logic signed [20:0]  a_gdiff_x_ff, a_gdiff_y_ff, a_gdiff_z_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                a_ready, b_ready;
   logic signed [19:0]  adiff_x, adiff_y, adiff_z;
   logic signed [20:0]  gdiff_x, gdiff_y, gdiff_z;

   assign b_ready    = !rsp_valid_ff || rsp_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign item_ready = a_ready;
   assign rsp_valid  = rsp_valid_ff;

   assign adiff_x = {{2{item.accel_x[17]}}, item.accel_x} -
                    {accel_offset_x[18], accel_offset_x};
   assign adiff_y = {{2{item.accel_y[17]}}, item.accel_y} -
                    {accel_offset_y[18], accel_offset_y};
   assign adiff_z = {{2{item.accel_z[17]}}, item.accel_z} -
                    {accel_offset_z[18], accel_offset_z};

   assign gdiff_x = {{2{item.gyro_x[18]}}, item.gyro_x} -
                    {gyro_offsets[19], gyro_offsets[19:0]};
   assign gdiff_y = {{2{item.gyro_y[18]}}, item.gyro_y} -
                    {gyro_offsets[39], gyro_offsets[39:20]};
   assign gdiff_z = {{2{item.gyro_z[18]}}, item.gyro_z} -
                    {gyro_offsets[59], gyro_offsets[59:40]};

   always_comb begin
      a_valid_in   = a_ready ? item_valid : a_valid_ff;
      rsp_valid_in = b_ready ? a_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (a_ready && item_valid) begin
         a_rejected_ff <= item.rejected;
         a_prod_x_ff   <= 37'(adiff_x) * 37'($signed({1'b0, accel_scale_x}));
         a_prod_y_ff   <= 37'(adiff_y) * 37'($signed({1'b0, accel_scale_y}));
         a_prod_z_ff   <= 37'(adiff_z) * 37'($signed({1'b0, accel_scale_z}));
         a_gdiff_x_ff  <= gdiff_x;
         a_gdiff_y_ff  <= gdiff_y;
         a_gdiff_z_ff  <= gdiff_z;
      end
   end

   // round, clamp and output register; a bad header zeroes every axis
   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         rsp_status <= a_rejected_ff;
         if (a_rejected_ff) begin
            rsp_accel_x <= '0;
            rsp_accel_y <= '0;
            rsp_accel_z <= '0;
            rsp_gyro_x  <= '0;
            rsp_gyro_y  <= '0;
            rsp_gyro_z  <= '0;
         end else begin
            rsp_accel_x <= sat_accel(a_prod_x_ff);
            rsp_accel_y <= sat_accel(a_prod_y_ff);
            rsp_accel_z <= sat_accel(a_prod_z_ff);
            rsp_gyro_x  <= sat_gyro(a_gdiff_x_ff);
            rsp_gyro_y  <= sat_gyro(a_gdiff_y_ff);
            rsp_gyro_z  <= sat_gyro(a_gdiff_z_ff);
         end
      end
   end

endmodule

### sv/imufpd_checker.sv
// port-level checks of the imu fifo packet decoder and their binding
module imufpd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [20:0] rsp_accel_x,
   input logic signed [20:0] rsp_accel_y,
   input logic signed [20:0] rsp_accel_z,
   input logic signed [19:0] rsp_gyro_x,
   input logic signed [19:0] rsp_gyro_y,
   input logic signed [19:0] rsp_gyro_z,
   input logic               rsp_status
);

   // a rejected header never carries axis data
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |->
         rsp_accel_x == '0 && rsp_accel_y == '0 && rsp_accel_z == '0 &&
         rsp_gyro_x == '0 && rsp_gyro_y == '0 && rsp_gyro_z == '0)
      else $error("rejected packet with nonzero axis fields");

   a_reset_no_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // empty queue after reset must take bytes at once
   a_reset_ready: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("request not ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) &&
         $stable(rsp_accel_x) && $stable(rsp_accel_y) && $stable(rsp_accel_z) &&
         $stable(rsp_gyro_x) && $stable(rsp_gyro_y) && $stable(rsp_gyro_z))
      else $error("stalled response changed");

endmodule

bind imu_fifo_packet_decoder imufpd_checker u_checker (.*);
